@@ hdl/crc_engine_multi_poly_macros.svh @@
// ----------------------------------------------------------------------------
// crc engine assertion macros
// shared concurrent assertion forms for the crc engine
// ----------------------------------------------------------------------------
`ifndef CRC_ENGINE_MULTI_POLY_MACROS_SVH
`define CRC_ENGINE_MULTI_POLY_MACROS_SVH

// checked out of reset only
`define CEMP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define CEMP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hdl/cemp_pkg.sv @@
// ----------------------------------------------------------------------------
// crc engine package
// register map, mode codes and bit helpers shared by the crc engine
// ----------------------------------------------------------------------------
package cemp_pkg;

  localparam int unsigned CrcW    = 32;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  localparam logic [CrcW-1:0] PolyCcitt = 32'h0000_1021;
  localparam logic [CrcW-1:0] PolyCrc16 = 32'h0000_8005;
  localparam logic [CrcW-1:0] PolyCrc32 = 32'h04C1_1DB7;

  typedef enum logic [1:0] {
    POLY_CCITT = 2'd0,
    POLY_CRC16 = 2'd1,
    POLY_CRC32 = 2'd2
  } poly_sel_e;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2,
    SIZE_NONE = 2'd3
  } size_e;

  typedef enum logic [2:0] {
    REG_POLY_SELECT      = 3'd0,
    REG_REVERSE_INPUT    = 3'd1,
    REG_COMPLEMENT_INPUT = 3'd2,
    REG_REVERSE_SUM      = 3'd3,
    REG_COMPLEMENT_SUM   = 3'd4,
    REG_SEED_VALUE       = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [1:0] poly_select;
    logic       reverse_input;
    logic       complement_input;
    logic       reverse_sum;
    logic       complement_sum;
  } cfg_t;

  typedef struct packed {
    logic            load;
    logic [CrcW-1:0] value;
  } seed_t;

  // code three behaves as the 32 bit polynomial
  function automatic logic crc_wide(logic [1:0] sel);
    logic wide;
    unique case (poly_sel_e'(sel))
      POLY_CCITT: wide = 1'b0;
      POLY_CRC16: wide = 1'b0;
      default:    wide = 1'b1;
    endcase
    return wide;
  endfunction

  function automatic logic [CrcW-1:0] crc_mask(logic [1:0] sel);
    return crc_wide(sel) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
  endfunction

  function automatic logic [CrcW-1:0] crc_poly(logic [1:0] sel);
    logic [CrcW-1:0] poly;
    unique case (poly_sel_e'(sel))
      POLY_CCITT: poly = PolyCcitt;
      POLY_CRC16: poly = PolyCrc16;
      default:    poly = PolyCrc32;
    endcase
    return poly;
  endfunction

  function automatic logic [7:0] rev8(logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic logic [CrcW-1:0] rev32(logic [CrcW-1:0] v);
    logic [CrcW-1:0] r;
    for (int i = 0; i < CrcW; i++) begin
      r[i] = v[CrcW-1-i];
    end
    return r;
  endfunction

endpackage

@@ hdl/crc_engine_multi_poly.sv @@
// ----------------------------------------------------------------------------
// crc engine, three polynomials
// register-controlled crc-ccitt / crc-16 / crc-32 over 8, 16 or 32 bit writes
// ----------------------------------------------------------------------------
//  channel  signals                                  direction
//  in       in_valid_i/in_ready_o, data_value_i,     sink
//           data_size_i
//  out      out_valid_o/out_ready_i, checksum_o      source
//  cfg      psel/penable/pwrite/paddr/pwdata/prdata  apb slave, pready tied high
//
//  one transaction a cycle sustained while out_ready_i is high
//  the four byte lanes are combinational between input and result registers
//  reset clears the modes, the seed and the running sum to zero
//  a stalled result holds the input register; inputs stall once both are full
// ----------------------------------------------------------------------------
module crc_engine_multi_poly (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cemp_pkg::AddrW-1:0] paddr,
  input  logic [cemp_pkg::DataW-1:0] pwdata,
  output logic [cemp_pkg::DataW-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [31:0]                data_value_i,
  input  logic [1:0]                 data_size_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [31:0]                checksum_o
);

  `include "crc_engine_multi_poly_macros.svh"

  cemp_pkg::cfg_t            cfg;
  cemp_pkg::seed_t           seed;
  logic                      in_valid_q;
  logic [31:0]               data_q;
  logic [1:0]                size_q;
  logic                      out_valid_q;
  logic [31:0]               checksum_q;
  logic [31:0]               checksum_d;
  logic [cemp_pkg::CrcW-1:0] crc_q;
  logic [cemp_pkg::CrcW-1:0] crc_d;
  logic [cemp_pkg::CrcW-1:0] crc_next;
  logic                      advance;
  logic                      in_fire;

  cemp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .seed_o  (seed)
  );

  cemp_update u_update (
    .crc_i  (crc_q),
    .data_i (data_q),
    .size_i (size_q),
    .cfg_i  (cfg),
    .crc_o  (crc_next),
    .sum_o  (checksum_d)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    crc_d = crc_q;
    if (seed.load) begin
      crc_d = seed.value;
    end else if (advance) begin
      crc_d = crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      crc_q       <= '0;
    end else begin
      crc_q <= crc_d;
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      data_q <= data_value_i;
      size_q <= data_size_i;
    end
    if (advance) begin
      checksum_q <= checksum_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign checksum_o  = checksum_q;

  `CEMP_ASSERT_ALWAYS(a_reset_no_result, !rst_ni |=> !out_valid_o, "result valid in reset")
  `CEMP_ASSERT(a_narrow_upper_zero,
    out_valid_o && !cemp_pkg::crc_wide(cfg.poly_select) |-> checksum_o[31:16] == 16'h0,
    "upper bits set on a 16 bit sum")
  `CEMP_ASSERT(a_size_none_holds,
    advance && size_q == cemp_pkg::SIZE_NONE && !seed.load |=> crc_q == $past(crc_q),
    "ignored width changed the running sum")
  `CEMP_ASSERT(a_stall_keeps_input,
    in_valid_q && out_valid_q && !out_ready_i |=> in_valid_q,
    "input register dropped during output stall")
  `CEMP_ASSERT(a_result_from_input,
    $rose(out_valid_q) |-> $past(in_valid_q),
    "result raised without a pending transaction")

endmodule

@@ hdl/cemp_regs.sv @@
// ----------------------------------------------------------------------------
// crc engine register block
// apb-style mode and seed registers; a seed write raises a load strobe
// ----------------------------------------------------------------------------
module cemp_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cemp_pkg::AddrW-1:0] paddr,
  input  logic [cemp_pkg::DataW-1:0] pwdata,
  output logic [cemp_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output cemp_pkg::cfg_t             cfg_o,
  output cemp_pkg::seed_t            seed_o
);

  cemp_pkg::cfg_t              cfg_q;
  cemp_pkg::cfg_t              cfg_d;
  logic [cemp_pkg::CrcW-1:0]   seed_q;
  logic [cemp_pkg::CrcW-1:0]   seed_d;
  logic                        wr_en;
  logic                        seed_wr;
  logic [2:0]                  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_comb begin
    cfg_d   = cfg_q;
    seed_d  = seed_q;
    seed_wr = 1'b0;
    if (wr_en) begin
      unique case (reg_idx)
        cemp_pkg::REG_POLY_SELECT:      cfg_d.poly_select      = pwdata[1:0];
        cemp_pkg::REG_REVERSE_INPUT:    cfg_d.reverse_input    = pwdata[0];
        cemp_pkg::REG_COMPLEMENT_INPUT: cfg_d.complement_input = pwdata[0];
        cemp_pkg::REG_REVERSE_SUM:      cfg_d.reverse_sum      = pwdata[0];
        cemp_pkg::REG_COMPLEMENT_SUM:   cfg_d.complement_sum   = pwdata[0];
        cemp_pkg::REG_SEED_VALUE: begin
          seed_d  = pwdata;
          seed_wr = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= '0;
      seed_q <= '0;
    end else begin
      cfg_q  <= cfg_d;
      seed_q <= seed_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      cemp_pkg::REG_POLY_SELECT:      prdata[1:0] = cfg_q.poly_select;
      cemp_pkg::REG_REVERSE_INPUT:    prdata[0]   = cfg_q.reverse_input;
      cemp_pkg::REG_COMPLEMENT_INPUT: prdata[0]   = cfg_q.complement_input;
      cemp_pkg::REG_REVERSE_SUM:      prdata[0]   = cfg_q.reverse_sum;
      cemp_pkg::REG_COMPLEMENT_SUM:   prdata[0]   = cfg_q.complement_sum;
      cemp_pkg::REG_SEED_VALUE:       prdata      = seed_q;
      default: ;
    endcase
  end

  // the running sum picks the seed up in the same edge as the register
  assign cfg_o        = cfg_q;
  assign seed_o.load  = seed_wr;
  assign seed_o.value = pwdata & cemp_pkg::crc_mask(cfg_q.poly_select);

endmodule

@@ hdl/cemp_byte.sv @@
// ----------------------------------------------------------------------------
// crc engine byte lane
// folds one data byte into the sum, msb first, at 16 or 32 bit width
// ----------------------------------------------------------------------------
module cemp_byte (
  input  logic [cemp_pkg::CrcW-1:0] crc_i,
  input  logic [7:0]                byte_i,
  input  logic                      en_i,
  input  cemp_pkg::cfg_t            cfg_i,
  output logic [cemp_pkg::CrcW-1:0] crc_o
);

  logic                      wide;
  logic [cemp_pkg::CrcW-1:0] mask;
  logic [cemp_pkg::CrcW-1:0] poly;
  logic [7:0]                b_inv;
  logic [7:0]                b_use;
  logic [cemp_pkg::CrcW-1:0] crc_w;
  logic                      top;

  assign wide  = cemp_pkg::crc_wide(cfg_i.poly_select);
  assign mask  = cemp_pkg::crc_mask(cfg_i.poly_select);
  assign poly  = cemp_pkg::crc_poly(cfg_i.poly_select);
  assign b_inv = cfg_i.complement_input ? ~byte_i : byte_i;
  assign b_use = cfg_i.reverse_input ? cemp_pkg::rev8(b_inv) : b_inv;

  always_comb begin
    crc_w = crc_i & mask;
    crc_w = crc_w ^ (wide ? {b_use, 24'h0} : {16'h0, b_use, 8'h0});
    top   = 1'b0;
    for (int i = 0; i < 8; i++) begin
      top   = wide ? crc_w[31] : crc_w[15];
      crc_w = (crc_w << 1) & mask;
      if (top) begin
        crc_w = crc_w ^ poly;
      end
    end
    // a disabled lane leaves the sum untouched, unmasked
    crc_o = en_i ? crc_w : crc_i;
  end

endmodule

@@ hdl/cemp_update.sv @@
// ----------------------------------------------------------------------------
// crc engine update
// chains four byte lanes, lsb byte first, and formats the read sum
// ----------------------------------------------------------------------------
module cemp_update (
  input  logic [cemp_pkg::CrcW-1:0]  crc_i,
  input  logic [cemp_pkg::DataW-1:0] data_i,
  input  logic [1:0]                 size_i,
  input  cemp_pkg::cfg_t             cfg_i,
  output logic [cemp_pkg::CrcW-1:0]  crc_o,
  output logic [cemp_pkg::CrcW-1:0]  sum_o
);

  logic [cemp_pkg::CrcW-1:0] chain [0:4];
  logic [3:0]                lane_en;
  logic [cemp_pkg::CrcW-1:0] mask;
  logic [cemp_pkg::CrcW-1:0] sum_m;
  logic [cemp_pkg::CrcW-1:0] sum_rev;
  logic [cemp_pkg::CrcW-1:0] sum_r;

  always_comb begin
    unique case (cemp_pkg::size_e'(size_i))
      cemp_pkg::SIZE_BYTE: lane_en = 4'b0001;
      cemp_pkg::SIZE_HALF: lane_en = 4'b0011;
      cemp_pkg::SIZE_WORD: lane_en = 4'b1111;
      cemp_pkg::SIZE_NONE: lane_en = 4'b0000;
      default:             lane_en = 4'b0000;
    endcase
  end

  assign chain[0] = crc_i;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    cemp_byte u_byte (
      .crc_i  (chain[g]),
      .byte_i (data_i[8*g +: 8]),
      .en_i   (lane_en[g]),
      .cfg_i  (cfg_i),
      .crc_o  (chain[g+1])
    );
  end

  assign crc_o = chain[4];

  // narrow sums reverse across the low 16 bits only
  assign mask    = cemp_pkg::crc_mask(cfg_i.poly_select);
  assign sum_m   = chain[4] & mask;
  assign sum_rev = cemp_pkg::rev32(sum_m);
  assign sum_r   = !cfg_i.reverse_sum ? sum_m :
                   cemp_pkg::crc_wide(cfg_i.poly_select) ? sum_rev :
                   {16'h0, sum_rev[31:16]};
  assign sum_o   = (cfg_i.complement_sum ? ~sum_r : sum_r) & mask;

endmodule
